// ----- src/scr_pkg.sv -----
package scr_pkg;

   localparam int unsigned DataWidth = 32;
   localparam int unsigned StepWidth = 31;
   localparam int unsigned AddrWidth = 5;
   localparam int unsigned IterCount = 32;

   // Register indexes (byte address / 4).
   localparam logic [2:0] REG_TIME_STEP      = 3'd0;
   localparam logic [2:0] REG_VISCOSITY      = 3'd1;
   localparam logic [2:0] REG_DIMENSION_MODE = 3'd2;
   localparam logic [2:0] REG_START_MODE     = 3'd3;
   localparam logic [2:0] REG_RESTART_STEP   = 3'd4;

   localparam logic [31:0] TimeStepReset  = 32'h0001_0000;
   localparam logic [31:0] ViscosityReset = 32'h0001_0000;

   typedef struct packed {
      logic signed [31:0] vel_x;
      logic signed [31:0] vel_y;
      logic signed [31:0] vel_z;
      logic [31:0]        core_size;
      logic signed [31:0] vorticity;
      logic [30:0]        step_index;
      logic               last_particle;
   } req_payload_type;

   typedef struct packed {
      logic [31:0]        avg_courant;
      logic [31:0]        avg_diffusion;
      logic signed [31:0] avg_mesh_re;
      logic [31:0]        step_max_courant;
      logic [31:0]        step_max_diffusion;
      logic [31:0]        step_max_mesh_re;
      logic [31:0]        run_max_courant;
      logic [31:0]        run_max_diffusion;
      logic [31:0]        run_max_mesh_re;
   } rsp_payload_type;

   typedef struct packed {
      logic [31:0] time_step;
      logic [31:0] viscosity;
      logic        dimension_mode;
      logic        start_mode;
      logic [30:0] restart_step;
   } csr_type;

   typedef logic [4:0] op_type;

   localparam op_type OP_NONE     = 5'd0;
   localparam op_type OP_LOAD     = 5'd1;
   localparam op_type OP_SQX      = 5'd2;
   localparam op_type OP_SQY      = 5'd3;
   localparam op_type OP_SQZ      = 5'd4;
   localparam op_type OP_SS       = 5'd5;
   localparam op_type OP_ND       = 5'd6;
   localparam op_type OP_RT_INIT  = 5'd7;
   localparam op_type OP_RT_STEP  = 5'd8;
   localparam op_type OP_SPD      = 5'd9;
   localparam op_type OP_C_START  = 5'd10;
   localparam op_type OP_DIV_STEP = 5'd11;
   localparam op_type OP_D_START  = 5'd12;
   localparam op_type OP_M0       = 5'd13;
   localparam op_type OP_M1       = 5'd14;
   localparam op_type OP_M_START  = 5'd15;
   localparam op_type OP_ACC      = 5'd16;
   localparam op_type OP_AC_START = 5'd17;
   localparam op_type OP_AD_START = 5'd18;
   localparam op_type OP_AM_START = 5'd19;
   localparam op_type OP_AM_END   = 5'd20;
   localparam op_type OP_EMIT     = 5'd21;

   typedef struct packed {
      op_type op;
   } dp_cmd_type;

   typedef struct packed {
      logic last_particle;
   } dp_status_type;

endpackage

// ----- src/scr_ctrl.sv -----
module scr_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   input  scr_pkg::dp_status_type status,
   output scr_pkg::dp_cmd_type   cmd
);

   localparam logic [4:0] ST_IDLE = 5'd0;
   localparam logic [4:0] ST_SQX  = 5'd1;
   localparam logic [4:0] ST_SQY  = 5'd2;
   localparam logic [4:0] ST_SQZ  = 5'd3;
   localparam logic [4:0] ST_SS   = 5'd4;
   localparam logic [4:0] ST_ND   = 5'd5;
   localparam logic [4:0] ST_RTI  = 5'd6;
   localparam logic [4:0] ST_RT   = 5'd7;
   localparam logic [4:0] ST_SPD  = 5'd8;
   localparam logic [4:0] ST_CST  = 5'd9;
   localparam logic [4:0] ST_CDV  = 5'd10;
   localparam logic [4:0] ST_DST  = 5'd11;
   localparam logic [4:0] ST_DDV  = 5'd12;
   localparam logic [4:0] ST_M0   = 5'd13;
   localparam logic [4:0] ST_M1   = 5'd14;
   localparam logic [4:0] ST_MST  = 5'd15;
   localparam logic [4:0] ST_MDV  = 5'd16;
   localparam logic [4:0] ST_ACC  = 5'd17;
   localparam logic [4:0] ST_ACS  = 5'd18;
   localparam logic [4:0] ST_ACV  = 5'd19;
   localparam logic [4:0] ST_ADS  = 5'd20;
   localparam logic [4:0] ST_ADV  = 5'd21;
   localparam logic [4:0] ST_AMS  = 5'd22;
   localparam logic [4:0] ST_AMV  = 5'd23;
   localparam logic [4:0] ST_AME  = 5'd24;
   localparam logic [4:0] ST_OUT  = 5'd25;

   localparam logic [4:0] LastIter = 5'(scr_pkg::IterCount - 1);

   logic [4:0] state_ff, state_in;
   logic [4:0] cnt_ff, cnt_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       loop_done;

   assign loop_done = (cnt_ff == LastIter);

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff & rsp_stall;
      cmd.op       = scr_pkg::OP_NONE;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.op   = scr_pkg::OP_LOAD;
               state_in = ST_SQX;
            end
         end
         ST_SQX: begin cmd.op = scr_pkg::OP_SQX;     state_in = ST_SQY; end
         ST_SQY: begin cmd.op = scr_pkg::OP_SQY;     state_in = ST_SQZ; end
         ST_SQZ: begin cmd.op = scr_pkg::OP_SQZ;     state_in = ST_SS;  end
         ST_SS:  begin cmd.op = scr_pkg::OP_SS;      state_in = ST_ND;  end
         ST_ND:  begin cmd.op = scr_pkg::OP_ND;      state_in = ST_RTI; end
         ST_RTI: begin cmd.op = scr_pkg::OP_RT_INIT; state_in = ST_RT;  end
         ST_RT: begin
            cmd.op = scr_pkg::OP_RT_STEP;
            cnt_in = cnt_ff + 5'd1;
            if (loop_done) state_in = ST_SPD;
         end
         ST_SPD: begin cmd.op = scr_pkg::OP_SPD;     state_in = ST_CST; end
         ST_CST: begin cmd.op = scr_pkg::OP_C_START; state_in = ST_CDV; end
         ST_CDV: begin
            cmd.op = scr_pkg::OP_DIV_STEP;
            cnt_in = cnt_ff + 5'd1;
            if (loop_done) state_in = ST_DST;
         end
         ST_DST: begin cmd.op = scr_pkg::OP_D_START; state_in = ST_DDV; end
         ST_DDV: begin
            cmd.op = scr_pkg::OP_DIV_STEP;
            cnt_in = cnt_ff + 5'd1;
            if (loop_done) state_in = ST_M0;
         end
         ST_M0:  begin cmd.op = scr_pkg::OP_M0;      state_in = ST_M1;  end
         ST_M1:  begin cmd.op = scr_pkg::OP_M1;      state_in = ST_MST; end
         ST_MST: begin cmd.op = scr_pkg::OP_M_START; state_in = ST_MDV; end
         ST_MDV: begin
            cmd.op = scr_pkg::OP_DIV_STEP;
            cnt_in = cnt_ff + 5'd1;
            if (loop_done) state_in = ST_ACC;
         end
         ST_ACC: begin
            cmd.op   = scr_pkg::OP_ACC;
            state_in = status.last_particle ? ST_ACS : ST_IDLE;
         end
         ST_ACS: begin cmd.op = scr_pkg::OP_AC_START; state_in = ST_ACV; end
         ST_ACV: begin
            cmd.op = scr_pkg::OP_DIV_STEP;
            cnt_in = cnt_ff + 5'd1;
            if (loop_done) state_in = ST_ADS;
         end
         ST_ADS: begin cmd.op = scr_pkg::OP_AD_START; state_in = ST_ADV; end
         ST_ADV: begin
            cmd.op = scr_pkg::OP_DIV_STEP;
            cnt_in = cnt_ff + 5'd1;
            if (loop_done) state_in = ST_AMS;
         end
         ST_AMS: begin cmd.op = scr_pkg::OP_AM_START; state_in = ST_AMV; end
         ST_AMV: begin
            cmd.op = scr_pkg::OP_DIV_STEP;
            cnt_in = cnt_ff + 5'd1;
            if (loop_done) state_in = ST_AME;
         end
         ST_AME: begin cmd.op = scr_pkg::OP_AM_END; state_in = ST_OUT; end
         ST_OUT: begin
            // The result register must be free, or being emptied this cycle.
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.op       = scr_pkg::OP_EMIT;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

// ----- src/scr_datapath.sv -----
module scr_datapath (
   input  logic                     clock,
   input  logic                     reset,
   input  scr_pkg::dp_cmd_type      cmd,
   output scr_pkg::dp_status_type   status,
   input  scr_pkg::csr_type         csr,
   input  scr_pkg::req_payload_type req_data,
   output scr_pkg::rsp_payload_type rsp_data
);

   scr_pkg::req_payload_type in_ff;
   scr_pkg::rsp_payload_type rsp_ff;

   logic [31:0] ax_ff, ay_ff, az_ff, aw_ff;
   logic [63:0] prod_ff, sq_ff, s2_ff, nd_ff, lo_ff;
   logic [63:0] rx_ff, rr_ff, ro_ff;
   logic [63:0] rem_ff, den_ff;
   logic [31:0] nlo_ff, q_ff;
   logic        over_ff;
   logic [31:0] cour_ff, diff_ff, ac_ff, ad_ff;
   logic signed [31:0] am_ff;

   logic [63:0] sum_c_ff, sum_d_ff;
   logic signed [63:0] sum_m_ff;
   logic [31:0] peak_c_ff, peak_d_ff, peak_m_ff, count_ff;
   logic [31:0] gpeak_c_ff, gpeak_d_ff, gpeak_m_ff;

   logic        three;
   logic [31:0] mul_a, mul_b;
   logic [63:0] mul_p;
   logic        mul_en;
   logic [95:0] div_num;
   logic [63:0] div_den;
   logic        div_start;
   logic [64:0] div_r2, div_diff;
   logic        div_ge;
   logic [31:0] div_res;
   logic [63:0] rt_sum;
   logic        rt_ge;
   logic [64:0] sc_sum, sd_sum;
   logic signed [63:0] mesh_ext, sm_sum, sm_sat;
   logic        sm_ovf;
   logic signed [31:0] mesh;
   logic [63:0] summ_mag;
   logic        init_step;
   logic [31:0] gc_new, gd_new, gm_new;

   function automatic logic [31:0] abs32(input logic signed [31:0] v);
      abs32 = v[31] ? (~v + 32'd1) : v;
   endfunction

   // Gives a magnitude its sign and clamps it to the signed 32-bit range.
   function automatic logic signed [31:0] sign_clamp(input logic [31:0] mag, input logic neg);
      logic signed [31:0] r;
      if (neg) begin
         r = (mag > 32'h8000_0000) ? 32'sh8000_0000 : (~mag + 32'd1);
      end else begin
         r = (mag > 32'h7FFF_FFFF) ? 32'sh7FFF_FFFF : mag;
      end
      sign_clamp = r;
   endfunction

   assign three = csr.dimension_mode;

   always_comb begin
      mul_a  = '0;
      mul_b  = '0;
      mul_en = 1'b1;
      case (cmd.op)
         scr_pkg::OP_SQX: begin mul_a = ax_ff;           mul_b = ax_ff;           end
         scr_pkg::OP_SQY: begin mul_a = ay_ff;           mul_b = ay_ff;           end
         scr_pkg::OP_SQZ: begin mul_a = az_ff;           mul_b = az_ff;           end
         scr_pkg::OP_SS:  begin mul_a = in_ff.core_size; mul_b = in_ff.core_size; end
         scr_pkg::OP_ND:  begin mul_a = csr.viscosity;   mul_b = csr.time_step;   end
         scr_pkg::OP_SPD: begin mul_a = rr_ff[31:0];     mul_b = csr.time_step;   end
         scr_pkg::OP_M0:  begin mul_a = aw_ff;           mul_b = s2_ff[31:0];     end
         scr_pkg::OP_M1:  begin mul_a = aw_ff;           mul_b = s2_ff[63:32];    end
         default:         mul_en = 1'b0;
      endcase
   end

   assign mul_p = mul_a * mul_b;

   assign summ_mag = sum_m_ff[63] ? (~sum_m_ff + 64'd1) : sum_m_ff;

   always_comb begin
      div_num   = '0;
      div_den   = '0;
      div_start = 1'b1;
      case (cmd.op)
         scr_pkg::OP_C_START: begin
            div_num = {32'd0, prod_ff};
            div_den = {32'd0, in_ff.core_size};
         end
         scr_pkg::OP_D_START: begin
            div_num = {16'd0, nd_ff, 16'd0};
            div_den = s2_ff;
         end
         scr_pkg::OP_M_START: begin
            if (three) begin
               div_num = {prod_ff, 32'd0} + {32'd0, lo_ff};
               div_den = {16'd0, csr.viscosity, 16'd0};
            end else begin
               div_num = {48'd0, aw_ff, 16'd0};
               div_den = {32'd0, csr.viscosity};
            end
         end
         scr_pkg::OP_AC_START: begin
            div_num = {32'd0, sum_c_ff};
            div_den = {32'd0, count_ff};
         end
         scr_pkg::OP_AD_START: begin
            div_num = {32'd0, sum_d_ff};
            div_den = {32'd0, count_ff};
         end
         scr_pkg::OP_AM_START: begin
            div_num = {32'd0, summ_mag};
            div_den = {32'd0, count_ff};
         end
         default: div_start = 1'b0;
      endcase
   end

   // Restoring division, one quotient bit a cycle. The quotient overflows
   // 32 bits exactly when the upper part of the dividend reaches the divisor.
   assign div_r2   = {rem_ff, nlo_ff[31]};
   assign div_ge   = (div_r2 >= {1'b0, den_ff});
   assign div_diff = div_r2 - {1'b0, den_ff};
   assign div_res  = over_ff ? 32'hFFFF_FFFF : q_ff;

   assign rt_sum = rr_ff + ro_ff;
   assign rt_ge  = (rx_ff >= rt_sum);

   assign mesh = sign_clamp(div_res, three & in_ff.vorticity[31]);

   assign sc_sum   = {1'b0, sum_c_ff} + {33'd0, cour_ff};
   assign sd_sum   = {1'b0, sum_d_ff} + {33'd0, diff_ff};
   assign mesh_ext = {{32{mesh[31]}}, mesh};
   assign sm_sum   = sum_m_ff + mesh_ext;
   assign sm_ovf   = (sum_m_ff[63] == mesh_ext[63]) && (sm_sum[63] != sum_m_ff[63]);
   assign sm_sat   = sum_m_ff[63] ? 64'sh8000_0000_0000_0000 : 64'sh7FFF_FFFF_FFFF_FFFF;

   assign init_step = csr.start_mode
      ? ({1'b0, in_ff.step_index} == ({1'b0, csr.restart_step} + 32'd1))
      : (in_ff.step_index == '0);

   assign gc_new = (init_step || (peak_c_ff > gpeak_c_ff)) ? peak_c_ff : gpeak_c_ff;
   assign gd_new = (init_step || (peak_d_ff > gpeak_d_ff)) ? peak_d_ff : gpeak_d_ff;
   assign gm_new = (init_step || (peak_m_ff > gpeak_m_ff)) ? peak_m_ff : gpeak_m_ff;

   // Working registers: no reset needed.
   always_ff @(posedge clock) begin
      if (mul_en) prod_ff <= mul_p;
      if (div_start) begin
         rem_ff  <= div_num[95:32];
         nlo_ff  <= div_num[31:0];
         den_ff  <= div_den;
         q_ff    <= '0;
         over_ff <= (div_num[95:32] >= div_den);
      end
      unique case (cmd.op)
         scr_pkg::OP_LOAD: begin
            in_ff <= req_data;
            ax_ff <= abs32(req_data.vel_x);
            ay_ff <= abs32(req_data.vel_y);
            az_ff <= abs32(req_data.vel_z);
            aw_ff <= abs32(req_data.vorticity);
         end
         scr_pkg::OP_SQY: sq_ff <= prod_ff;
         scr_pkg::OP_SQZ: sq_ff <= sq_ff + prod_ff;
         scr_pkg::OP_SS:  sq_ff <= three ? (sq_ff + prod_ff) : sq_ff;
         scr_pkg::OP_ND:  s2_ff <= prod_ff;
         scr_pkg::OP_RT_INIT: begin
            nd_ff <= prod_ff;
            rx_ff <= sq_ff;
            rr_ff <= '0;
            ro_ff <= 64'h4000_0000_0000_0000;
         end
         scr_pkg::OP_RT_STEP: begin
            if (rt_ge) begin
               rx_ff <= rx_ff - rt_sum;
               rr_ff <= (rr_ff >> 1) + ro_ff;
            end else begin
               rr_ff <= rr_ff >> 1;
            end
            ro_ff <= ro_ff >> 2;
         end
         scr_pkg::OP_DIV_STEP: begin
            if (div_ge) rem_ff <= div_diff[63:0];
            else        rem_ff <= div_r2[63:0];
            nlo_ff <= {nlo_ff[30:0], 1'b0};
            q_ff   <= {q_ff[30:0], div_ge};
         end
         scr_pkg::OP_D_START:  cour_ff <= div_res;
         scr_pkg::OP_M0:       diff_ff <= div_res;
         scr_pkg::OP_M1:       lo_ff   <= prod_ff;
         scr_pkg::OP_AD_START: ac_ff   <= div_res;
         scr_pkg::OP_AM_START: ad_ff   <= div_res;
         scr_pkg::OP_AM_END:   am_ff   <= sign_clamp(div_res, sum_m_ff[63]);
         scr_pkg::OP_EMIT: begin
            rsp_ff.avg_courant        <= ac_ff;
            rsp_ff.avg_diffusion      <= ad_ff;
            rsp_ff.avg_mesh_re        <= am_ff;
            rsp_ff.step_max_courant   <= peak_c_ff;
            rsp_ff.step_max_diffusion <= peak_d_ff;
            rsp_ff.step_max_mesh_re   <= peak_m_ff;
            rsp_ff.run_max_courant    <= gc_new;
            rsp_ff.run_max_diffusion  <= gd_new;
            rsp_ff.run_max_mesh_re    <= gm_new;
         end
         default: ;
      endcase
   end

   // Step accumulators and run maxima.
   always_ff @(posedge clock) begin
      if (reset) begin
         sum_c_ff   <= '0;
         sum_d_ff   <= '0;
         sum_m_ff   <= '0;
         peak_c_ff  <= '0;
         peak_d_ff  <= '0;
         peak_m_ff  <= '0;
         count_ff   <= '0;
         gpeak_c_ff <= '0;
         gpeak_d_ff <= '0;
         gpeak_m_ff <= '0;
      end else if (cmd.op == scr_pkg::OP_ACC) begin
         sum_c_ff <= sc_sum[64] ? 64'hFFFF_FFFF_FFFF_FFFF : sc_sum[63:0];
         sum_d_ff <= sd_sum[64] ? 64'hFFFF_FFFF_FFFF_FFFF : sd_sum[63:0];
         sum_m_ff <= sm_ovf ? sm_sat : sm_sum;
         if (cour_ff > peak_c_ff) peak_c_ff <= cour_ff;
         if (diff_ff > peak_d_ff) peak_d_ff <= diff_ff;
         if (!mesh[31] && (mesh > peak_m_ff)) peak_m_ff <= mesh;
         if (count_ff != 32'hFFFF_FFFF) count_ff <= count_ff + 32'd1;
      end else if (cmd.op == scr_pkg::OP_EMIT) begin
         sum_c_ff   <= '0;
         sum_d_ff   <= '0;
         sum_m_ff   <= '0;
         peak_c_ff  <= '0;
         peak_d_ff  <= '0;
         peak_m_ff  <= '0;
         count_ff   <= '0;
         gpeak_c_ff <= gc_new;
         gpeak_d_ff <= gd_new;
         gpeak_m_ff <= gm_new;
      end
   end

   assign status.last_particle = in_ff.last_particle;
   assign rsp_data             = rsp_ff;

endmodule

// ----- src/stability_criteria_reducer.sv -----
// Each particle holds off the next one until it is through; in that time it runs
// the square root loop and the shared restoring divider, used three times.
// A particle marked last also takes the divider for the three averages, and its
// result is held back while the previous result is unread.
// Synchronous active-high reset clears the accumulators, run maxima and CSRs.
module stability_criteria_reducer (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  scr_pkg::req_payload_type req_data,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output scr_pkg::rsp_payload_type rsp_data,
   input  logic                     psel,
   input  logic                     penable,
   input  logic                     pwrite,
   input  logic [4:0]               paddr,
   input  logic [31:0]              pwdata,
   output logic [31:0]              prdata,
   output logic                     pready
);

   scr_pkg::csr_type       csr_ff;
   scr_pkg::dp_cmd_type    cmd;
   scr_pkg::dp_status_type status;
   logic                   csr_wr;
   logic [2:0]             csr_idx;

   assign csr_idx = paddr[4:2];
   assign csr_wr  = psel & penable & pwrite;
   assign pready  = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff.time_step      <= scr_pkg::TimeStepReset;
         csr_ff.viscosity      <= scr_pkg::ViscosityReset;
         csr_ff.dimension_mode <= 1'b0;
         csr_ff.start_mode     <= 1'b0;
         csr_ff.restart_step   <= '0;
      end else if (csr_wr) begin
         unique case (csr_idx)
            scr_pkg::REG_TIME_STEP:      csr_ff.time_step      <= pwdata;
            scr_pkg::REG_VISCOSITY:      csr_ff.viscosity      <= pwdata;
            scr_pkg::REG_DIMENSION_MODE: csr_ff.dimension_mode <= pwdata[0];
            scr_pkg::REG_START_MODE:     csr_ff.start_mode     <= pwdata[0];
            scr_pkg::REG_RESTART_STEP:   csr_ff.restart_step   <= pwdata[30:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_idx)
         scr_pkg::REG_TIME_STEP:      prdata = csr_ff.time_step;
         scr_pkg::REG_VISCOSITY:      prdata = csr_ff.viscosity;
         scr_pkg::REG_DIMENSION_MODE: prdata = {31'd0, csr_ff.dimension_mode};
         scr_pkg::REG_START_MODE:     prdata = {31'd0, csr_ff.start_mode};
         scr_pkg::REG_RESTART_STEP:   prdata = {1'b0, csr_ff.restart_step};
         default:                     prdata = '0;
      endcase
   end

   scr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   scr_datapath u_datapath (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .status   (status),
      .csr      (csr_ff),
      .req_data (req_data),
      .rsp_data (rsp_data)
   );

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 100ps

module tb_top;

   logic clock;
   logic reset;
   logic req_valid;
   logic req_stall;
   scr_pkg::req_payload_type req_data;
   logic rsp_valid;
   logic rsp_stall;
   scr_pkg::rsp_payload_type rsp_data;
   logic psel;
   logic penable;
   logic pwrite;
   logic [4:0] paddr;
   logic [31:0] pwdata;
   logic [31:0] prdata;
   logic pready;

   stability_criteria_reducer dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   // Predictor state: a copy of the registers and the accumulators.
   scr_pkg::csr_type cfg;
   logic [63:0] acc_courant, acc_diffusion;
   longint acc_mesh;
   logic [31:0] top_courant, top_diffusion, top_mesh, n_particles;
   logic [31:0] run_courant, run_diffusion, run_mesh;

   scr_pkg::req_payload_type particle_queue[$];
   scr_pkg::rsp_payload_type summary_queue[$];

   int sender_idle_pct, receiver_idle_pct;
   int hold_cycles;
   bit hold_request;
   int errors = 0;
   int quiet_cycles;

   localparam int QuietLimit = 20000;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic logic [63:0] root_floor(input logic [63:0] x);
      logic [63:0] r;
      logic [63:0] bitv;
      r = 0;
      bitv = 64'h4000_0000_0000_0000;
      while (bitv > x) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (x >= r + bitv) begin
            x = x - (r + bitv);
            r = (r >> 1) + bitv;
         end else begin
            r = r >> 1;
         end
         bitv = bitv >> 2;
      end
      return r;
   endfunction

   // Floor of a 128-bit dividend over d, saturated to 32 bits.
   function automatic logic [31:0] quotient_sat(input logic [127:0] num, input logic [63:0] d);
      logic [127:0] q;
      if (d == 0) return 32'hFFFF_FFFF;
      q = num / {64'd0, d};
      return (q > 128'hFFFF_FFFF) ? 32'hFFFF_FFFF : q[31:0];
   endfunction

   function automatic logic [63:0] sum_sat(input logic [63:0] a, input logic [63:0] b);
      logic [64:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[64] ? 64'hFFFF_FFFF_FFFF_FFFF : s[63:0];
   endfunction

   function automatic longint signed_sum_sat(input longint a, input longint b);
      longint s;
      s = a + b;
      if (b > 0 && s < a) return 64'sh7FFF_FFFF_FFFF_FFFF;
      if (b < 0 && s > a) return 64'sh8000_0000_0000_0000;
      return s;
   endfunction

   // Folds one particle into the step accumulators; returns 1 with the summary
   // when the particle closes a step.
   function automatic bit fold_particle(input scr_pkg::req_payload_type p,
                                        output scr_pkg::rsp_payload_type r);
      longint vx, vy, vz, w;
      logic [63:0] sq, speed, s, s2, p_nd, mag_w, mag;
      logic [31:0] cour, diff;
      longint mesh, am;
      logic [63:0] ac, ad;
      bit init;
      vx = p.vel_x; vy = p.vel_y; vz = p.vel_z; w = p.vorticity;
      s = {32'd0, p.core_size};
      sq = vx * vx + vy * vy;
      if (cfg.dimension_mode) sq = sq + vz * vz;
      speed = root_floor(sq);
      cour = quotient_sat({64'd0, speed * cfg.time_step}, s);
      p_nd = {32'd0, cfg.viscosity} * {32'd0, cfg.time_step};
      s2 = s * s;
      diff = quotient_sat({48'd0, p_nd, 16'd0}, s2);
      mag_w = (w < 0) ? -w : w;
      if (!cfg.dimension_mode)
         mag = quotient_sat({48'd0, mag_w, 16'd0}, {32'd0, cfg.viscosity});
      else
         mag = quotient_sat({64'd0, mag_w} * {64'd0, s2}, {16'd0, cfg.viscosity, 16'd0});
      if (cfg.dimension_mode && w < 0)
         mesh = (mag > 64'h8000_0000) ? -64'sh8000_0000 : -longint'(mag);
      else
         mesh = (mag > 64'h7FFF_FFFF) ? 64'sh7FFF_FFFF : longint'(mag);

      acc_courant = sum_sat(acc_courant, {32'd0, cour});
      acc_diffusion = sum_sat(acc_diffusion, {32'd0, diff});
      acc_mesh = signed_sum_sat(acc_mesh, mesh);
      if (cour > top_courant) top_courant = cour;
      if (diff > top_diffusion) top_diffusion = diff;
      if (mesh > longint'({32'd0, top_mesh})) top_mesh = mesh[31:0];
      if (n_particles != 32'hFFFF_FFFF) n_particles = n_particles + 32'd1;
      if (!p.last_particle) return 0;

      ac = acc_courant / n_particles;
      ad = acc_diffusion / n_particles;
      am = acc_mesh / longint'({32'd0, n_particles});
      if (ac > 64'hFFFF_FFFF) ac = 64'hFFFF_FFFF;
      if (ad > 64'hFFFF_FFFF) ad = 64'hFFFF_FFFF;
      if (am > 64'sh7FFF_FFFF) am = 64'sh7FFF_FFFF;
      if (am < -64'sh8000_0000) am = -64'sh8000_0000;
      init = cfg.start_mode ? ({1'b0, p.step_index} == {1'b0, cfg.restart_step} + 32'd1)
                            : (p.step_index == 0);
      if (init || top_courant > run_courant) run_courant = top_courant;
      if (init || top_diffusion > run_diffusion) run_diffusion = top_diffusion;
      if (init || top_mesh > run_mesh) run_mesh = top_mesh;
      r.avg_courant = ac[31:0];
      r.avg_diffusion = ad[31:0];
      r.avg_mesh_re = am[31:0];
      r.step_max_courant = top_courant;
      r.step_max_diffusion = top_diffusion;
      r.step_max_mesh_re = top_mesh;
      r.run_max_courant = run_courant;
      r.run_max_diffusion = run_diffusion;
      r.run_max_mesh_re = run_mesh;
      acc_courant = 0; acc_diffusion = 0; acc_mesh = 0;
      top_courant = 0; top_diffusion = 0; top_mesh = 0; n_particles = 0;
      return 1;
   endfunction

   // Sender.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_data <= '0;
         acc_courant = 0; acc_diffusion = 0; acc_mesh = 0;
         top_courant = 0; top_diffusion = 0; top_mesh = 0; n_particles = 0;
         run_courant = 0; run_diffusion = 0; run_mesh = 0;
      end else begin
         if (req_valid && !req_stall) begin
            scr_pkg::rsp_payload_type r;
            if (fold_particle(req_data, r)) summary_queue.push_back(r);
         end
         if (!req_valid || !req_stall) begin
            if (particle_queue.size() > 0 && $urandom_range(99) >= sender_idle_pct) begin
               req_valid <= 1'b1;
               req_data <= particle_queue.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Receiver and checker.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         hold_cycles <= 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (summary_queue.size() == 0) begin
               $error("unexpected result beat");
               errors++;
            end else begin
               scr_pkg::rsp_payload_type e;
               e = summary_queue.pop_front();
               if (rsp_data.avg_courant !== e.avg_courant) begin
                  $error("avg_courant exp %h got %h", e.avg_courant, rsp_data.avg_courant);
                  errors++;
               end
               if (rsp_data.avg_diffusion !== e.avg_diffusion) begin
                  $error("avg_diffusion exp %h got %h", e.avg_diffusion, rsp_data.avg_diffusion);
                  errors++;
               end
               if (rsp_data.avg_mesh_re !== e.avg_mesh_re) begin
                  $error("avg_mesh_re exp %h got %h", e.avg_mesh_re, rsp_data.avg_mesh_re);
                  errors++;
               end
               if (rsp_data.step_max_courant !== e.step_max_courant) begin
                  $error("step_max_courant exp %h got %h", e.step_max_courant,
                         rsp_data.step_max_courant);
                  errors++;
               end
               if (rsp_data.step_max_diffusion !== e.step_max_diffusion) begin
                  $error("step_max_diffusion exp %h got %h", e.step_max_diffusion,
                         rsp_data.step_max_diffusion);
                  errors++;
               end
               if (rsp_data.step_max_mesh_re !== e.step_max_mesh_re) begin
                  $error("step_max_mesh_re exp %h got %h", e.step_max_mesh_re,
                         rsp_data.step_max_mesh_re);
                  errors++;
               end
               if (rsp_data.run_max_courant !== e.run_max_courant) begin
                  $error("run_max_courant exp %h got %h", e.run_max_courant,
                         rsp_data.run_max_courant);
                  errors++;
               end
               if (rsp_data.run_max_diffusion !== e.run_max_diffusion) begin
                  $error("run_max_diffusion exp %h got %h", e.run_max_diffusion,
                         rsp_data.run_max_diffusion);
                  errors++;
               end
               if (rsp_data.run_max_mesh_re !== e.run_max_mesh_re) begin
                  $error("run_max_mesh_re exp %h got %h", e.run_max_mesh_re,
                         rsp_data.run_max_mesh_re);
                  errors++;
               end
            end
         end
         // A long hold-off lets particles pile up behind an unread result.
         if (hold_request && hold_cycles == 0) begin
            hold_cycles <= 2000;
            rsp_stall <= 1'b1;
         end else if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            rsp_stall <= (hold_cycles > 1);
         end else begin
            rsp_stall <= ($urandom_range(99) < receiver_idle_pct);
         end
      end
   end

   // Watchdog on cycles with no accepted beat.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) || hold_cycles > 0)
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles > QuietLimit) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
      @(posedge clock);
      psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
      paddr <= {idx, 2'b00}; pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
      case (idx)
         scr_pkg::REG_TIME_STEP: cfg.time_step = value;
         scr_pkg::REG_VISCOSITY: cfg.viscosity = value;
         scr_pkg::REG_DIMENSION_MODE: cfg.dimension_mode = value[0];
         scr_pkg::REG_START_MODE: cfg.start_mode = value[0];
         scr_pkg::REG_RESTART_STEP: cfg.restart_step = value[30:0];
         default: ;
      endcase
   endtask

   task automatic wait_drained();
      while (particle_queue.size() > 0 || req_valid || summary_queue.size() > 0)
         @(posedge clock);
      // A particle that is not last may still be in the datapath.
      repeat (300) @(posedge clock);
   endtask

   function automatic logic [31:0] pick_word();
      case ($urandom_range(5))
         0: return 32'h8000_0000;
         1: return 32'h7FFF_FFFF;
         2: return 32'hFFFF_FFFF;
         3: return $urandom_range(32'h0003_FFFF);
         4: return -$urandom_range(32'h0003_FFFF);
         default: return $urandom;
      endcase
   endfunction

   function automatic scr_pkg::req_payload_type make_particle(input logic [30:0] step,
                                                              input bit last);
      scr_pkg::req_payload_type p;
      p.vel_x = pick_word();
      p.vel_y = pick_word();
      p.vel_z = pick_word();
      p.core_size = ($urandom_range(7) == 0) ? pick_word() : $urandom_range(32'h0004_0000);
      if (p.core_size == 0) p.core_size = 1;
      p.vorticity = pick_word();
      p.step_index = step;
      p.last_particle = last;
      return p;
   endfunction

   // Queues one simulation step of n particles.
   task automatic queue_step(input logic [30:0] step, input int n);
      for (int i = 0; i < n; i++) particle_queue.push_back(make_particle(step, i == n - 1));
   endtask

   initial begin
      scr_pkg::req_payload_type p;
      int issued;
      logic [30:0] step;
      hold_request = 0;
      sender_idle_pct = 18; receiver_idle_pct = 61;
      reset = 1'b1;
      psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
      cfg.time_step = scr_pkg::TimeStepReset; cfg.viscosity = scr_pkg::ViscosityReset;
      cfg.dimension_mode = 0; cfg.start_mode = 0; cfg.restart_step = 0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Directed: extremes under reset settings, then in 3D, then in 3D with restart mode.
      p = '0; p.core_size = 32'h0001_0000; p.last_particle = 1;
      particle_queue.push_back(p);
      p.vel_x = 32'sh8000_0000; p.vel_y = 32'sh8000_0000; p.vel_z = 32'sh8000_0000;
      p.core_size = 1; p.vorticity = 32'sh8000_0000; p.step_index = 31'h7FFF_FFFF;
      p.last_particle = 0;
      particle_queue.push_back(p);
      p.vel_x = 32'sh7FFF_FFFF; p.core_size = 32'hFFFF_FFFF; p.vorticity = 32'sh7FFF_FFFF;
      p.last_particle = 1;
      particle_queue.push_back(p);
      wait_drained();
      write_reg(scr_pkg::REG_DIMENSION_MODE, 1);
      write_reg(scr_pkg::REG_TIME_STEP, 32'hFFFF_FFFF);
      write_reg(scr_pkg::REG_VISCOSITY, 1);
      p = '0; p.vel_z = 32'sh0002_0000; p.core_size = 32'h0001_0000;
      p.vorticity = -32'sh0001_0000; p.step_index = '0;
      particle_queue.push_back(p);
      p.vorticity = 32'sh8000_0000; p.core_size = 32'hFFFF_FFFF;
      particle_queue.push_back(p);
      p.vorticity = -32'sh0000_0001; p.core_size = 1; p.last_particle = 1;
      particle_queue.push_back(p);
      queue_step(31'd5, 4);
      wait_drained();
      write_reg(scr_pkg::REG_START_MODE, 1);
      write_reg(scr_pkg::REG_RESTART_STEP, 32'h7FFF_FFFE);
      queue_step(31'h7FFF_FFFF, 3);
      queue_step(31'd3, 2);
      wait_drained();

      // Random phases: each with its own settings; idling changes at phases 2 and 4.
      issued = 0;
      for (int phase = 0; phase < 6; phase++) begin
         if (phase == 2) begin
            sender_idle_pct = 61; receiver_idle_pct = 18;
         end else if (phase == 4) begin
            sender_idle_pct = 0; receiver_idle_pct = 0;
         end
         write_reg(scr_pkg::REG_TIME_STEP,
                   (phase == 5) ? 32'd1 : $urandom_range(32'h0004_0000, 1));
         write_reg(scr_pkg::REG_VISCOSITY, (phase == 3) ? 32'hFFFF_FFFF :
                                 $urandom_range(32'h0004_0000, 1));
         write_reg(scr_pkg::REG_DIMENSION_MODE, {31'd0, phase[0]});
         write_reg(scr_pkg::REG_START_MODE, {31'd0, phase[1]});
         write_reg(scr_pkg::REG_RESTART_STEP, $urandom_range(40));
         step = cfg.start_mode ? (cfg.restart_step + 31'd1) : '0;
         if (phase == 1) hold_request = 1;
         while (issued < (phase + 1) * 255) begin
            int n;
            n = $urandom_range(12, 1);
            queue_step(($urandom_range(9) == 0) ? 31'($urandom) : step, n);
            issued += n;
            step = step + 31'd1;
            if ($urandom_range(7) == 0) step = cfg.start_mode ? (cfg.restart_step + 31'd1) : '0;
            while (particle_queue.size() > 8) @(posedge clock);
            if (hold_cycles > 0) hold_request = 0;
         end
         hold_request = 0;
         // The sender waits for every expected result before new settings.
         wait_drained();
      end
      repeat (300) @(posedge clock);
      if (errors == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule
